@@ hdl/complex_arithmetic_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit assertion macros
// Shorthand for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// Condition and consequence in the same cycle.
`define CAU_ASSERT_NOW(lbl, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("complex arithmetic unit check failed");

// Consequence in the cycle after the condition.
`define CAU_ASSERT_NEXT(lbl, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("complex arithmetic unit check failed");

`endif

@@ hdl/cau_pkg.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Widths, beat types, opcodes and shared arithmetic helpers.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int PART_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_W     = 2 * PART_WIDTH;
    localparam int SUM_W      = PROD_W + 1;
    localparam int NUM_W      = SUM_W + FRAC_BITS;
    localparam int HI_W       = NUM_W - PART_WIDTH;
    localparam int DEN_W      = PROD_W;
    localparam int CMP_W      = (HI_W > DEN_W) ? HI_W : DEN_W;

    typedef logic signed [PART_WIDTH-1:0] part_t;
    typedef logic signed [PART_WIDTH:0]   part_x_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [SUM_W-1:0]      sum_t;
    typedef logic signed [NUM_W-1:0]      num_t;
    typedef logic [DEN_W-1:0]             den_t;
    typedef logic [CMP_W-1:0]             cmp_t;
    typedef logic [PART_WIDTH-1:0]        quo_t;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_NEG = 3'd2,
        OP_MUL = 3'd3,
        OP_DIV = 3'd4,
        OP_INC = 3'd5
    } op_t;

    typedef struct packed {
        logic [2:0] opcode;
        part_t      a_re;
        part_t      a_im;
        part_t      b_re;
        part_t      b_im;
    } in_beat_t;

    typedef struct packed {
        part_t res_re;
        part_t res_im;
        logic  divide_by_zero;
        logic  saturated;
    } out_beat_t;

    typedef struct packed {
        part_t val;
        logic  sat;
    } clip_t;

    // One division in flight: partial remainder, remaining numerator bits that
    // turn into quotient bits, sign and early overflow.
    typedef struct packed {
        den_t rem;
        quo_t low;
        logic neg;
        logic ovf;
    } div_t;

    typedef struct packed {
        logic [2:0] opcode;
        logic       dz;
        logic       sat;
        part_t      re;
        part_t      im;
        den_t       den;
        div_t       dre;
        div_t       dim;
    } cell_t;

    function automatic clip_t clip_part(sum_t v);
        clip_t r;
        r.sat = 1'b0;
        r.val = v[PART_WIDTH-1:0];
        if (!(v[SUM_W-1:PART_WIDTH-1] == '0 || v[SUM_W-1:PART_WIDTH-1] == '1))
        begin
            r.sat = 1'b1;
            r.val = v[SUM_W-1] ? {1'b1, {(PART_WIDTH-1){1'b0}}}
                               : {1'b0, {(PART_WIDTH-1){1'b1}}};
        end
        return r;
    endfunction

    // Scale the numerator, take its magnitude and split it. The high part
    // already at or above the divisor means the quotient cannot fit.
    function automatic div_t div_prep(sum_t s, den_t d);
        num_t              n;
        logic [NUM_W-1:0]  mag;
        logic [HI_W-1:0]   hi;
        div_t              r;
        n     = num_t'(s) <<< FRAC_BITS;
        mag   = n[NUM_W-1] ? -n : n;
        hi    = mag[NUM_W-1:PART_WIDTH];
        r.neg = n[NUM_W-1];
        r.ovf = cmp_t'(hi) >= cmp_t'(d);
        r.rem = den_t'(hi);
        r.low = mag[PART_WIDTH-1:0];
        return r;
    endfunction

    function automatic clip_t div_final(div_t x);
        quo_t  half;
        clip_t r;
        half  = {1'b1, {(PART_WIDTH-1){1'b0}}};
        r.sat = 1'b0;
        r.val = x.low;
        if (x.neg) begin
            if (x.ovf || x.low > half) begin
                r.sat = 1'b1;
                r.val = {1'b1, {(PART_WIDTH-1){1'b0}}};
            end
            else begin
                r.val = -x.low;
            end
        end
        else if (x.ovf || x.low >= half) begin
            r.sat = 1'b1;
            r.val = {1'b0, {(PART_WIDTH-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

@@ hdl/cau_front.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit front end
// Input register, product stage and preparation of the divide chain.
// ----------------------------------------------------------------------------
module cau_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              src_valid,
    input  cau_pkg::in_beat_t src_data,
    output logic              out_vld,
    output cau_pkg::cell_t    out_cell
);

    cau_pkg::in_beat_t s1_reg;
    logic              s1_vld_reg;

    logic              s2_vld_reg;
    logic [2:0]        s2_op_reg;
    cau_pkg::clip_t    s2_sre_reg, s2_sim_reg;
    cau_pkg::prod_t    p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, p_bb_reg, p_cc_reg;

    cau_pkg::cell_t    s3_reg, s3_next;
    logic              s3_vld_reg;

    cau_pkg::part_x_t  ar_x, ai_x, br_x, bi_x, one_x, s_re, s_im;
    cau_pkg::clip_t    sre_c, sim_c;
    cau_pkg::sum_t     mre, mim, dre, dim;
    cau_pkg::clip_t    mre_c, mim_c;
    cau_pkg::den_t     den;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else if (adv) begin
            s1_vld_reg <= src_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    assign ar_x  = s1_reg.a_re;
    assign ai_x  = s1_reg.a_im;
    assign br_x  = s1_reg.b_re;
    assign bi_x  = s1_reg.b_im;
    assign one_x = cau_pkg::part_x_t'(1) <<< cau_pkg::FRAC_BITS;

    always_comb
    begin
        s_re = '0;
        s_im = '0;
        case (s1_reg.opcode)
            cau_pkg::OP_ADD: begin s_re = ar_x + br_x;  s_im = ai_x + bi_x;  end
            cau_pkg::OP_SUB: begin s_re = ar_x - br_x;  s_im = ai_x - bi_x;  end
            cau_pkg::OP_NEG: begin s_re = -ar_x;        s_im = -ai_x;        end
            cau_pkg::OP_INC: begin s_re = ar_x + one_x; s_im = ai_x + one_x; end
            default:         begin s_re = '0;           s_im = '0;           end
        endcase
    end

    assign sre_c = cau_pkg::clip_part(cau_pkg::sum_t'(s_re));
    assign sim_c = cau_pkg::clip_part(cau_pkg::sum_t'(s_im));

    always_ff @(posedge clk)
    begin
        if (adv) begin
            s1_reg     <= src_data;
            s2_op_reg  <= s1_reg.opcode;
            s2_sre_reg <= sre_c;
            s2_sim_reg <= sim_c;
            p_rr_reg   <= s1_reg.a_re * s1_reg.b_re;
            p_ii_reg   <= s1_reg.a_im * s1_reg.b_im;
            p_ri_reg   <= s1_reg.a_re * s1_reg.b_im;
            p_ir_reg   <= s1_reg.a_im * s1_reg.b_re;
            p_bb_reg   <= s1_reg.b_re * s1_reg.b_re;
            p_cc_reg   <= s1_reg.b_im * s1_reg.b_im;
            s3_reg     <= s3_next;
        end
    end

    assign mre   = cau_pkg::sum_t'(p_rr_reg) - cau_pkg::sum_t'(p_ii_reg);
    assign mim   = cau_pkg::sum_t'(p_ri_reg) + cau_pkg::sum_t'(p_ir_reg);
    assign mre_c = cau_pkg::clip_part(mre >>> cau_pkg::FRAC_BITS);
    assign mim_c = cau_pkg::clip_part(mim >>> cau_pkg::FRAC_BITS);
    assign dre   = cau_pkg::sum_t'(p_rr_reg) + cau_pkg::sum_t'(p_ii_reg);
    assign dim   = cau_pkg::sum_t'(p_ir_reg) - cau_pkg::sum_t'(p_ri_reg);
    assign den   = cau_pkg::den_t'($unsigned(p_bb_reg))
                 + cau_pkg::den_t'($unsigned(p_cc_reg));

    always_comb
    begin
        s3_next        = '0;
        s3_next.opcode = s2_op_reg;
        s3_next.den    = den;
        s3_next.dre    = cau_pkg::div_prep(dre, den);
        s3_next.dim    = cau_pkg::div_prep(dim, den);
        case (s2_op_reg)
            cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_NEG, cau_pkg::OP_INC:
            begin
                s3_next.re  = s2_sre_reg.val;
                s3_next.im  = s2_sim_reg.val;
                s3_next.sat = s2_sre_reg.sat | s2_sim_reg.sat;
            end
            cau_pkg::OP_MUL:
            begin
                s3_next.re  = mre_c.val;
                s3_next.im  = mim_c.val;
                s3_next.sat = mre_c.sat | mim_c.sat;
            end
            cau_pkg::OP_DIV:
            begin
                s3_next.dz = (den == '0);
            end
            default:
            begin
                s3_next.sat = 1'b0;
            end
        endcase
    end

    assign out_vld  = s3_vld_reg;
    assign out_cell = s3_reg;

endmodule

@@ hdl/cau_div_cell.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit divider cell
// One restoring quotient bit for the real and imaginary division.
// ----------------------------------------------------------------------------
module cau_div_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_vld,
    input  cau_pkg::cell_t in_cell,
    output logic           out_vld,
    output cau_pkg::cell_t out_cell
);

    cau_pkg::cell_t cell_reg, cell_next;
    logic           vld_reg;

    function automatic cau_pkg::div_t div_step(cau_pkg::div_t x, cau_pkg::den_t d);
        logic [cau_pkg::DEN_W:0] t;
        logic                    q;
        cau_pkg::div_t           r;
        t     = {x.rem, x.low[cau_pkg::PART_WIDTH-1]};
        q     = (t >= {1'b0, d});
        r     = x;
        r.rem = q ? cau_pkg::den_t'(t - {1'b0, d}) : t[cau_pkg::DEN_W-1:0];
        r.low = {x.low[cau_pkg::PART_WIDTH-2:0], q};
        return r;
    endfunction

    always_comb
    begin
        cell_next     = in_cell;
        cell_next.dre = div_step(in_cell.dre, in_cell.den);
        cell_next.dim = div_step(in_cell.dim, in_cell.den);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= 1'b0;
        end
        else if (adv) begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            cell_reg <= cell_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_cell = cell_reg;

endmodule

@@ hdl/complex_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Add, subtract, negate, multiply, divide and increment on Q16.16 complex
// operands, with saturation and a zero divisor flag.
// ----------------------------------------------------------------------------
//   channel | handshake          | beat
//   src     | src_valid/src_stall | opcode, a_re, a_im, b_re, b_im
//   dst     | dst_valid/dst_stall | res_re, res_im, divide_by_zero, saturated
//
// One beat is taken every cycle while src_stall is low. Each beat goes
// through three front stages (input, products, sums), one divider cell per
// result bit and an output register before its result is valid, and a beat
// waits in place for as long as the pipeline is frozen.
// Every opcode takes the same path, so results leave in order.
// Reset clears only the valid bits of the stages.
// A result that waits in the output register under dst_stall freezes the
// whole pipeline and raises src_stall in the same cycle.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    output logic                src_stall,
    input  cau_pkg::in_beat_t   src_data,
    output logic                dst_valid,
    input  logic                dst_stall,
    output cau_pkg::out_beat_t  dst_data
);

    localparam int NCELL = cau_pkg::PART_WIDTH;

    // The pipeline moves as one whenever the output register can take a beat.
    logic adv;

    logic           chain_vld [0:NCELL];
    cau_pkg::cell_t chain     [0:NCELL];

    cau_pkg::out_beat_t dst_data_reg, dst_data_next;
    logic               dst_valid_reg;
    cau_pkg::clip_t     q_re, q_im;
    cau_pkg::cell_t     last;

    assign adv       = !(dst_valid_reg && dst_stall);
    assign src_stall = !adv;

    cau_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .src_valid (src_valid),
        .src_data  (src_data),
        .out_vld   (chain_vld[0]),
        .out_cell  (chain[0])
    );

    // Each cell produces one quotient bit of both divisions, most significant
    // bit first, and passes the rest of the beat along unchanged.
    for (genvar g = 0; g < NCELL; g++)
    begin : g_cell
        cau_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .in_vld   (chain_vld[g]),
            .in_cell  (chain[g]),
            .out_vld  (chain_vld[g+1]),
            .out_cell (chain[g+1])
        );
    end

    assign last = chain[NCELL];
    assign q_re = cau_pkg::div_final(last.dre);
    assign q_im = cau_pkg::div_final(last.dim);

    // Non-divide results were settled in the front end; a divide takes its
    // quotients here unless the divisor was zero, which gives zero.
    always_comb
    begin
        dst_data_next                = '0;
        dst_data_next.res_re         = last.re;
        dst_data_next.res_im         = last.im;
        dst_data_next.saturated      = last.sat;
        dst_data_next.divide_by_zero = 1'b0;
        if (last.opcode == cau_pkg::OP_DIV)
        begin
            if (last.dz)
            begin
                dst_data_next.res_re         = '0;
                dst_data_next.res_im         = '0;
                dst_data_next.saturated      = 1'b0;
                dst_data_next.divide_by_zero = 1'b1;
            end
            else
            begin
                dst_data_next.res_re    = q_re.val;
                dst_data_next.res_im    = q_im.val;
                dst_data_next.saturated = q_re.sat | q_im.sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dst_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            dst_valid_reg <= chain_vld[NCELL];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dst_data_reg <= dst_data_next;
        end
    end

    assign dst_valid = dst_valid_reg;
    assign dst_data  = dst_data_reg;

endmodule

@@ hdl/cau_checker.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit port checker
// Checks on the ports of the unit over time, bound to the top level.
// ----------------------------------------------------------------------------
`include "complex_arithmetic_unit_assert.svh"

module cau_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               src_valid,
    input logic               src_stall,
    input cau_pkg::in_beat_t  src_data,
    input logic               dst_valid,
    input logic               dst_stall,
    input cau_pkg::out_beat_t dst_data
);

    logic  sat_edge;

    assign sat_edge = dst_data.res_re == {1'b1, {(cau_pkg::PART_WIDTH-1){1'b0}}}
                   || dst_data.res_re == {1'b0, {(cau_pkg::PART_WIDTH-1){1'b1}}}
                   || dst_data.res_im == {1'b1, {(cau_pkg::PART_WIDTH-1){1'b0}}}
                   || dst_data.res_im == {1'b0, {(cau_pkg::PART_WIDTH-1){1'b1}}};

    // A held result stays put.
    `CAU_ASSERT_NEXT(a_dst_hold, dst_valid && dst_stall, dst_valid && $stable(dst_data))
    // Input back-pressure comes only from a waiting result.
    `CAU_ASSERT_NOW(a_src_stall_cause, src_stall, dst_valid && dst_stall)
    // A zero divisor gives a clean zero result.
    `CAU_ASSERT_NOW(a_dz_zero, dst_valid && dst_data.divide_by_zero,
                    dst_data.res_re == '0 && dst_data.res_im == '0 && !dst_data.saturated)
    // A clipped result sits at one of the limits.
    `CAU_ASSERT_NOW(a_sat_limit, dst_valid && dst_data.saturated, sat_edge)
    // A valid result beat carries only known bits.
    `CAU_ASSERT_NOW(a_dst_known, dst_valid, !$isunknown(dst_data))

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);
